>>> rtl/sensor_min_max_sum_tracker_defines.svh
// Assertion macros shared by the sensor statistics RTL.
// Files that assert include this header; it depends on nothing else.
// Every macro assumes a clock named clk and an active-low reset named arst_n.
`ifndef SENSOR_MIN_MAX_SUM_TRACKER_DEFINES_SVH
`define SENSOR_MIN_MAX_SUM_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while the block is in reset.
`define SMMST_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while the block is in reset.
`define SMMST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/smmst_pkg.sv
// Package for the sensor statistics tracker: payload types, channel codes
// and fixed widths. Depends on nothing; the front, queue, back and top import it.
package smmst_pkg;

	localparam int VALUE_W    = 32;
	localparam int TIME_W     = 32;
	localparam int SUM_W      = 48;
	localparam int COUNT_W    = 32;
	localparam int SF_OUT_W   = 6;
	localparam int SF_IDX_W   = 4;
	localparam int SF_BASE    = 7;
	localparam int STAT_CHANNELS = 3;
	localparam int CHAN_W     = 2;

	// Short queue between front and back; depth must be a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Channel codes carried in the func field.
	localparam logic [2:0] FUNC_TEMP  = 3'd0;
	localparam logic [2:0] FUNC_HUM   = 3'd1;
	localparam logic [2:0] FUNC_PRES  = 3'd2;
	localparam logic [2:0] FUNC_BATT  = 3'd3;
	localparam logic [2:0] FUNC_SF    = 3'd4;

	// Item classes decided by the front.
	localparam logic [1:0] KIND_STAT = 2'd0;
	localparam logic [1:0] KIND_BATT = 2'd1;
	localparam logic [1:0] KIND_SF   = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic                      site;
		logic [2:0]                func;
		logic signed [VALUE_W-1:0] value;
		logic [TIME_W-1:0]         sample_time;
		logic                      record_start;
	} sample_t;

	typedef struct packed {
		logic                      result_site;
		logic signed [SUM_W-1:0]   running_sum;
		logic signed [VALUE_W-1:0] highest_value;
		logic [TIME_W-1:0]         highest_time;
		logic signed [VALUE_W-1:0] lowest_value;
		logic [TIME_W-1:0]         lowest_time;
		logic [TIME_W-1:0]         earliest_time;
		logic [TIME_W-1:0]         latest_time;
		logic signed [VALUE_W-1:0] battery_start;
		logic signed [VALUE_W-1:0] battery_end;
		logic [SF_OUT_W-1:0]       sf_map;
		logic [COUNT_W-1:0]        records_seen;
	} result_t;

	// Classified item passed from front to back through the queue.
	typedef struct packed {
		logic                      site;
		logic [1:0]                kind;
		logic [CHAN_W-1:0]         chan;
		logic signed [VALUE_W-1:0] value;
		logic [TIME_W-1:0]         sample_time;
		logic                      record_start;
		logic                      sf_hit;
		logic [SF_IDX_W-1:0]       sf_idx;
	} item_t;

endpackage

>>> rtl/smmst_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for the sample, internal item and result channels; no dependencies.
interface smmst_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/smmst_front.sv
// Front end: accepts samples and classifies them into queue items.
// Depends on smmst_pkg and smmst_stream_if.
module smmst_front import smmst_pkg::*; #(
	parameter int NUM_SITES = 2,
	parameter int NUM_SF    = 6
) (
	smmst_stream_if.sink   sample,
	smmst_stream_if.source item
);

	logic [15:0] sf_int;
	logic [15:0] sf_off;
	logic [1:0]  kind;

	// The front holds nothing; it passes the handshake straight to the queue.
	assign sample.ready = item.ready;
	assign item.valid   = sample.valid;

	// Integer part of a non-negative Q16.16 value is its upper half.
	assign sf_int = sample.data.value[31:16];
	assign sf_off = sf_int - 16'(SF_BASE);

	// Decode the channel code into an item class.
	always_comb begin
		unique case (sample.data.func)
			FUNC_TEMP, FUNC_HUM, FUNC_PRES: kind = KIND_STAT;
			FUNC_BATT:                      kind = KIND_BATT;
			FUNC_SF:                        kind = KIND_SF;
			default:                        kind = KIND_NONE;
		endcase
	end

	// Build the classified item.
	always_comb begin
		item.data.site         = (NUM_SITES < 2) ? 1'b0 : sample.data.site;
		item.data.kind         = kind;
		item.data.chan         = (kind == KIND_STAT) ? sample.data.func[CHAN_W-1:0] : '0;
		item.data.value        = sample.data.value;
		item.data.sample_time  = sample.data.sample_time;
		item.data.record_start = sample.data.record_start;
		item.data.sf_hit       = !sample.data.value[31] && (sf_int >= 16'(SF_BASE))
			&& (sf_off < 16'(NUM_SF));
		item.data.sf_idx       = sf_off[SF_IDX_W-1:0];
	end

endmodule

>>> rtl/smmst_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on smmst_pkg, smmst_stream_if and the assertion macro header.
`include "sensor_min_max_sum_tracker_defines.svh"

module smmst_queue import smmst_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	smmst_stream_if.sink   push,
	smmst_stream_if.source pop
);

	item_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.data   = entries_q[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	// Pointers wrap naturally as the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Item storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.data;
		end
	end

	`SMMST_ASSERT(a_count_bound, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
	`SMMST_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_q == $past(count_q) + QCNT_W'(1), "push lost")
	`SMMST_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_q == $past(count_q) - QCNT_W'(1), "pop lost")

endmodule

>>> rtl/smmst_back.sv
// Back end: applies each item to the site statistics and registers the result.
// Depends on smmst_pkg, smmst_stream_if and the assertion macro header.
`include "sensor_min_max_sum_tracker_defines.svh"

module smmst_back import smmst_pkg::*; #(
	parameter int NUM_SITES = 2,
	parameter int NUM_SF    = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	smmst_stream_if.sink   item,
	smmst_stream_if.source result
);

	// Only two sites can be addressed by the one-bit site field.
	localparam int USED_SITES = (NUM_SITES < 2) ? NUM_SITES : 2;
	localparam int SF_PAD_W   = (NUM_SF > SF_OUT_W) ? NUM_SF : SF_OUT_W;

	// Per-site, per-channel statistics.
	logic signed [SUM_W-1:0]   sum_q      [USED_SITES][STAT_CHANNELS];
	logic signed [VALUE_W-1:0] max_q      [USED_SITES][STAT_CHANNELS];
	logic [TIME_W-1:0]         max_time_q [USED_SITES][STAT_CHANNELS];
	logic signed [VALUE_W-1:0] min_q      [USED_SITES][STAT_CHANNELS];
	logic [TIME_W-1:0]         min_time_q [USED_SITES][STAT_CHANNELS];
	// Per-site statistics.
	logic [TIME_W-1:0]         first_q    [USED_SITES];
	logic [TIME_W-1:0]         last_q     [USED_SITES];
	logic signed [VALUE_W-1:0] batt_first_q [USED_SITES];
	logic signed [VALUE_W-1:0] batt_last_q  [USED_SITES];
	logic [NUM_SF-1:0]         sf_q       [USED_SITES];
	logic [COUNT_W-1:0]        rec_q      [USED_SITES];

	logic    out_valid_q;
	result_t out_q;

	item_t                     cur;
	logic                      take;
	logic [TIME_W-1:0]         new_first;
	logic [TIME_W-1:0]         new_last;
	logic [COUNT_W-1:0]        new_rec;
	logic signed [SUM_W:0]     sum_ext;
	logic signed [SUM_W-1:0]   new_sum;
	logic                      max_upd;
	logic                      min_upd;
	logic signed [VALUE_W-1:0] new_max;
	logic [TIME_W-1:0]         new_max_time;
	logic signed [VALUE_W-1:0] new_min;
	logic [TIME_W-1:0]         new_min_time;
	logic                      batt_first_upd;
	logic                      batt_last_upd;
	logic signed [VALUE_W-1:0] new_batt_first;
	logic signed [VALUE_W-1:0] new_batt_last;
	logic [NUM_SF-1:0]         sf_bit;
	logic [NUM_SF-1:0]         new_sf;
	logic [SF_PAD_W-1:0]       sf_pad;
	result_t                   res;

	assign cur          = item.data;
	assign item.ready   = !out_valid_q || result.ready;
	assign take         = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Period bounds and record count of the addressed site.
	always_comb begin
		new_first = (cur.sample_time < first_q[cur.site]) ? cur.sample_time : first_q[cur.site];
		new_last  = (cur.sample_time > last_q[cur.site]) ? cur.sample_time : last_q[cur.site];
		new_rec   = rec_q[cur.site];
		if (cur.record_start && (rec_q[cur.site] != '1)) begin
			new_rec = rec_q[cur.site] + COUNT_W'(1);
		end
	end

	// Saturating sum and extremes of the addressed channel.
	always_comb begin
		sum_ext = {sum_q[cur.site][cur.chan][SUM_W-1], sum_q[cur.site][cur.chan]}
			+ {{(SUM_W + 1 - VALUE_W){cur.value[VALUE_W-1]}}, cur.value};
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			new_sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			new_sum = sum_ext[SUM_W-1:0];
		end
		max_upd      = (cur.value > max_q[cur.site][cur.chan]);
		min_upd      = (cur.value < min_q[cur.site][cur.chan]);
		new_max      = max_upd ? cur.value : max_q[cur.site][cur.chan];
		new_max_time = max_upd ? cur.sample_time : max_time_q[cur.site][cur.chan];
		new_min      = min_upd ? cur.value : min_q[cur.site][cur.chan];
		new_min_time = min_upd ? cur.sample_time : min_time_q[cur.site][cur.chan];
	end

	// Battery values at the period bounds, and the spreading-factor bitmap.
	always_comb begin
		batt_first_upd = (cur.kind == KIND_BATT) && (new_first == cur.sample_time);
		batt_last_upd  = (cur.kind == KIND_BATT) && (new_last == cur.sample_time);
		new_batt_first = batt_first_upd ? cur.value : batt_first_q[cur.site];
		new_batt_last  = batt_last_upd ? cur.value : batt_last_q[cur.site];
		sf_bit         = NUM_SF'(1) << cur.sf_idx;
		new_sf         = sf_q[cur.site];
		if ((cur.kind == KIND_SF) && cur.sf_hit) begin
			new_sf = sf_q[cur.site] | sf_bit;
		end
		sf_pad = SF_PAD_W'(new_sf);
	end

	// Result of the item, from the updated statistics.
	always_comb begin
		res.result_site   = cur.site;
		res.running_sum   = '0;
		res.highest_value = '0;
		res.highest_time  = '0;
		res.lowest_value  = '0;
		res.lowest_time   = '0;
		if (cur.kind == KIND_STAT) begin
			res.running_sum   = new_sum;
			res.highest_value = new_max;
			res.highest_time  = new_max_time;
			res.lowest_value  = new_min;
			res.lowest_time   = new_min_time;
		end
		res.earliest_time = new_first;
		res.latest_time   = new_last;
		res.battery_start = new_batt_first;
		res.battery_end   = new_batt_last;
		res.sf_map        = sf_pad[SF_OUT_W-1:0];
		res.records_seen  = new_rec;
	end

	// Statistics update, one item per cycle while the result output is not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < USED_SITES; s++) begin
				for (int c = 0; c < STAT_CHANNELS; c++) begin
					sum_q[s][c]      <= '0;
					max_q[s][c]      <= {1'b1, {(VALUE_W-1){1'b0}}};
					max_time_q[s][c] <= '0;
					min_q[s][c]      <= {1'b0, {(VALUE_W-1){1'b1}}};
					min_time_q[s][c] <= '0;
				end
				first_q[s]      <= '1;
				last_q[s]       <= '0;
				batt_first_q[s] <= '0;
				batt_last_q[s]  <= '0;
				sf_q[s]         <= '0;
				rec_q[s]        <= '0;
			end
		end else if (take) begin
			first_q[cur.site] <= new_first;
			last_q[cur.site]  <= new_last;
			rec_q[cur.site]   <= new_rec;
			unique case (cur.kind)
				KIND_STAT: begin
					sum_q[cur.site][cur.chan]      <= new_sum;
					max_q[cur.site][cur.chan]      <= new_max;
					max_time_q[cur.site][cur.chan] <= new_max_time;
					min_q[cur.site][cur.chan]      <= new_min;
					min_time_q[cur.site][cur.chan] <= new_min_time;
				end
				KIND_BATT: begin
					batt_first_q[cur.site] <= new_batt_first;
					batt_last_q[cur.site]  <= new_batt_last;
				end
				KIND_SF: begin
					sf_q[cur.site] <= new_sf;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: holds a result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item.ready) begin
			out_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	`SMMST_ASSERT_NEXT(a_min_le_max, take && (cur.kind == KIND_STAT), $signed(out_q.lowest_value) <= $signed(out_q.highest_value), "minimum above maximum")
	`SMMST_ASSERT_NEXT(a_period_order, take, out_q.earliest_time <= out_q.latest_time, "period bounds out of order")
	`SMMST_ASSERT(a_records_monotonic, 1'b1, rec_q[0] >= $past(rec_q[0]), "record count decreased")

endmodule

>>> rtl/sensor_min_max_sum_tracker.sv
// Top level of the sensor statistics tracker: front, item queue and back.
// Depends on smmst_pkg, smmst_stream_if, smmst_front, smmst_queue, smmst_back.
//
//  Port    | Dir | Payload   | Handshake
//  --------+-----+-----------+-------------------------------
//  sample  | in  | sample_t  | valid/ready, taken when both high
//  result  | out | result_t  | valid/ready, taken when both high
//
// One item is taken per cycle sustained while the result is not stalled; a
// result becomes valid once its item has passed through the queue entry
// and then been written into the output register.
// The rate is set by the back stage, which reads and updates the addressed
// site's statistics registers combinationally and writes them on each take.
// Reset sets every statistic to its initial value at once; no clearing pass.
// A stalled result holds in the output register; the two-entry queue keeps
// sample.ready high until it fills.
module sensor_min_max_sum_tracker import smmst_pkg::*; #(
	parameter int NUM_SITES = 2,
	parameter int NUM_SF    = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	smmst_stream_if.sink   sample,
	smmst_stream_if.source result
);

	smmst_stream_if #(.T(item_t)) front_items ();
	smmst_stream_if #(.T(item_t)) back_items ();

	// Classification of incoming samples.
	smmst_front #(
		.NUM_SITES (NUM_SITES),
		.NUM_SF    (NUM_SF)
	) u_front (
		.sample (sample),
		.item   (front_items)
	);

	// Decoupling queue.
	smmst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_items),
		.pop    (back_items)
	);

	// Statistics update and result register.
	smmst_back #(
		.NUM_SITES (NUM_SITES),
		.NUM_SF    (NUM_SF)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (back_items),
		.result (result)
	);

endmodule
